@@ hw/rtl/lease_lock_with_wait_queue_unit_defines.svh @@
// Assertion macros for the lease lock unit.
// Define NO_ASSERTIONS to compile them out.
`ifndef LEASE_LOCK_WITH_WAIT_QUEUE_UNIT_DEFINES_SVH
`define LEASE_LOCK_WITH_WAIT_QUEUE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LLWQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LLWQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LLWQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LLWQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/llwq_pkg.sv @@
package llwq_pkg;

   // default sizes
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int ID_BITS_DEF     = 16;

   // action codes
   localparam logic [1:0] ACT_STATIC = 2'd0;
   localparam logic [1:0] ACT_TEMP   = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // response codes
   localparam logic [1:0] RESP_FILLED   = 2'd0;
   localparam logic [1:0] RESP_QUEUED   = 2'd1;
   localparam logic [1:0] RESP_REJECTED = 2'd2;
   localparam logic [1:0] RESP_NONE     = 2'd3;

   // lock state codes
   localparam logic [1:0] LOCK_NONE   = 2'd0;
   localparam logic [1:0] LOCK_STATIC = 2'd1;
   localparam logic [1:0] LOCK_TEMP   = 2'd2;

   // per-cycle commands broadcast to every queue cell
   typedef struct packed {
      logic append;   // empty cell right after the last entry takes the id
      logic refresh;  // matching cell marks itself fresh
      logic age;      // drop stale entries, mark the rest stale
      logic shift;    // cells at or above the first hole take the upper neighbor
   } cell_ctl_type;

endpackage

@@ hw/rtl/llwq_cell.sv @@
module llwq_cell
   import llwq_pkg::*;
#(
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [ID_BITS-1:0] req_id,
   input  logic               prev_valid,
   input  logic               hole_in,
   input  logic               next_valid,
   input  logic [ID_BITS-1:0] next_id,
   input  logic               next_fresh,
   output logic               valid,
   output logic               fresh,
   output logic [ID_BITS-1:0] id,
   output logic               hit,
   output logic               hole_out
);

   logic               valid_ff, valid_in;
   logic               fresh_ff, fresh_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               hole;

   assign hit      = valid_ff && (id_ff == req_id);
   // a hole at or below this cell pulls everything above it down by one
   assign hole     = hole_in || !valid_ff;
   assign hole_out = hole;

   // next entry contents
   always_comb begin
      valid_in = valid_ff;
      fresh_in = fresh_ff;
      id_in    = id_ff;
      priority if (ctl.shift) begin
         if (hole) begin
            valid_in = next_valid;
            fresh_in = next_fresh;
            id_in    = next_id;
         end
      end else if (ctl.age) begin
         valid_in = valid_ff && fresh_ff;
         fresh_in = 1'b0;
      end else if (ctl.append && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         fresh_in = 1'b1;
         id_in    = req_id;
      end else if (ctl.refresh && hit) begin
         fresh_in = 1'b1;
      end else begin
         fresh_in = fresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload, meaningful only while valid
   always_ff @(posedge clock) begin
      fresh_ff <= fresh_in;
      id_ff    <= id_in;
   end

   assign valid = valid_ff;
   assign fresh = fresh_ff;
   assign id    = id_ff;

endmodule

@@ hw/rtl/lease_lock_with_wait_queue_unit.sv @@
// Channel  | Ports                                           | Direction
// ---------+-------------------------------------------------+----------
// request  | req_valid req_ready req_action req_requester    | in
// response | rsp_valid rsp_ready rsp_response rsp_lock_state | out
//          | rsp_queue_length                                |
//
// Each lock request executes in the cell chain, then loads the output register
// while the next word is taken when words arrive back to back. An aging tick
// ages the queue in the cell chain; the queue then closes its gaps by shifting
// one slot per cycle down the cell chain before the result loads.
// Reset empties the queue and clears the static holder.
// A stalled result holds in the output register; one more word is taken
// behind it and executed, then input waits until the result leaves.
`include "lease_lock_with_wait_queue_unit_defines.svh"

module lease_lock_with_wait_queue_unit
   import llwq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF,
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [ID_BITS-1:0] req_requester,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_response,
   output logic [1:0]         rsp_lock_state,
   output logic [CNT_W-1:0]   rsp_queue_length
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_EXEC    = 4'b0010,
      ST_COMPACT = 4'b0100,
      ST_OUT     = 4'b1000
   } fsm_state_type;

   fsm_state_type       state_ff, state_in;
   logic [1:0]          action_ff;
   logic [ID_BITS-1:0]  req_id_ff;
   logic [ID_BITS-1:0]  holder_ff, holder_in;
   logic [1:0]          resp_code_ff, resp_code_in;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_response_ff;
   logic [1:0]          rsp_lock_state_ff;
   logic [CNT_W-1:0]    rsp_queue_length_ff;

   cell_ctl_type           cell_ctl;
   logic [QUEUE_DEPTH-1:0] valid_vec, fresh_vec, hit_vec, hole_vec, gap_vec, edge_vec;
   logic [ID_BITS-1:0]     id_arr [QUEUE_DEPTH];
   logic [CNT_W-1:0]       queue_cnt;
   logic                   out_free, accept, load_out, hit_any, gap_any, full, empty;
   logic [1:0]             lock_now;

   // ---- cell chain ----
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic               prev_v, hole_i, next_v, next_f;
      logic [ID_BITS-1:0] next_i;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
         assign hole_i = 1'b0;
      end else begin : g_rest
         assign prev_v = valid_vec[i-1];
         assign hole_i = hole_vec[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_v     = 1'b0;
         assign next_f     = 1'b0;
         assign next_i     = '0;
         assign gap_vec[i] = 1'b0;
         assign edge_vec[i] = valid_vec[i];
      end else begin : g_mid
         assign next_v     = valid_vec[i+1];
         assign next_f     = fresh_vec[i+1];
         assign next_i     = id_arr[i+1];
         assign gap_vec[i] = !valid_vec[i] && valid_vec[i+1];
         assign edge_vec[i] = valid_vec[i] && !valid_vec[i+1];
      end

      llwq_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .req_id     (req_id_ff),
         .prev_valid (prev_v),
         .hole_in    (hole_i),
         .next_valid (next_v),
         .next_id    (next_i),
         .next_fresh (next_f),
         .valid      (valid_vec[i]),
         .fresh      (fresh_vec[i]),
         .id         (id_arr[i]),
         .hit        (hit_vec[i]),
         .hole_out   (hole_vec[i])
      );
   end

   // queue status; entries are packed from cell 0 whenever compaction is done
   assign hit_any = |hit_vec;
   assign gap_any = |gap_vec;
   assign full    = valid_vec[QUEUE_DEPTH-1];
   assign empty   = !valid_vec[0];

   // length from the top edge of the packed valid bits
   always_comb begin
      queue_cnt = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (edge_vec[i]) begin
            queue_cnt = queue_cnt | CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      if (holder_ff != '0) begin
         lock_now = LOCK_STATIC;
      end else if (valid_vec[0]) begin
         lock_now = LOCK_TEMP;
      end else begin
         lock_now = LOCK_NONE;
      end
   end

   // ---- handshake ----
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_OUT) && out_free);
   assign accept    = req_valid && req_ready;

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      cell_ctl     = '0;
      holder_in    = holder_ff;
      resp_code_in = resp_code_ff;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            unique case (action_ff)
               ACT_STATIC: begin
                  if ((holder_ff == '0) && empty) begin
                     holder_in    = req_id_ff;
                     resp_code_in = RESP_FILLED;
                  end else begin
                     resp_code_in = RESP_REJECTED;
                  end
               end
               ACT_TEMP: begin
                  if (hit_any) begin
                     cell_ctl.refresh = 1'b1;
                     resp_code_in     = hit_vec[0] ? RESP_FILLED : RESP_QUEUED;
                  end else if (full) begin
                     resp_code_in = RESP_REJECTED;
                  end else begin
                     cell_ctl.append = 1'b1;
                     resp_code_in    = empty ? RESP_FILLED : RESP_QUEUED;
                  end
               end
               ACT_TICK: begin
                  cell_ctl.age = 1'b1;
                  resp_code_in = RESP_NONE;
                  state_in     = ST_COMPACT;
               end
               ACT_UNUSED: begin
                  resp_code_in = RESP_NONE;
               end
            endcase
         end
         ST_COMPACT: begin
            if (gap_any) begin
               cell_ctl.shift = 1'b1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         holder_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         holder_ff <= holder_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // captured word and result payload
   always_ff @(posedge clock) begin
      resp_code_ff <= resp_code_in;
      if (accept) begin
         action_ff <= req_action;
         req_id_ff <= req_requester;
      end
      if (load_out) begin
         rsp_response_ff     <= resp_code_ff;
         rsp_lock_state_ff   <= lock_now;
         rsp_queue_length_ff <= queue_cnt;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_response     = rsp_response_ff;
   assign rsp_lock_state   = rsp_lock_state_ff;
   assign rsp_queue_length = rsp_queue_length_ff;

   // ---- checks ----
   `LLWQ_ASSERT_IMP(a_ids_unique, clock, reset, 1'b1, $onehot0(hit_vec), "duplicate queue id")
   `LLWQ_ASSERT_IMP(a_packed_out, clock, reset, state_ff == ST_OUT, gap_vec == '0, "queue not packed")
   `LLWQ_ASSERT_NXT(a_append_grows, clock, reset, (state_ff == ST_EXEC) && cell_ctl.append, $countones(valid_vec) == $countones($past(valid_vec)) + 1, "append lost")

endmodule
